FILE: rtl/core/htt_pkg.sv
package htt_pkg;

    localparam int MAX_VERTICES = 65536;
    localparam int FACE_SLOTS   = 4096;
    localparam int COORD_BITS   = 32;

    localparam int VIDX_W  = 16;
    localparam int VADDR_W = $clog2(MAX_VERTICES);
    localparam int FADDR_W = $clog2(FACE_SLOTS);
    localparam int FCNT_W  = FADDR_W + 1;
    localparam int XYZ_W   = 3 * COORD_BITS;
    localparam int KEY_W   = 3 * VIDX_W;
    localparam int ACC_W   = COORD_BITS + 3;
    localparam int OUT_C_W = 32;

    localparam int HEX_CORNERS  = 8;
    localparam int QUAD_CORNERS = 4;
    localparam int HEX_TETS     = 24;
    localparam int MAX_NEW_VTX  = 7;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_HEX  = 2'd1;
    localparam logic [1:0] CMD_FACE = 2'd2;

    localparam logic [1:0] KIND_VERTEX = 2'd0;
    localparam logic [1:0] KIND_TET    = 2'd1;
    localparam logic [1:0] KIND_TRI    = 2'd2;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_FULL    = 2'd1;
    localparam logic [1:0] ERR_NO_FACE = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FULL,
        S_CELL_ACC,
        S_KEY,
        S_SEARCH,
        S_FACE_ACC,
        S_EMIT_V,
        S_EMIT_T,
        S_Q_EMIT,
        S_Q_ERR
    } state_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [VIDX_W-1:0] node_a;
        logic [VIDX_W-1:0] node_b;
        logic [VIDX_W-1:0] node_c;
        logic [VIDX_W-1:0] node_d;
        logic [OUT_C_W-1:0] coord_x;
        logic [OUT_C_W-1:0] coord_y;
        logic [OUT_C_W-1:0] coord_z;
        logic              last;
        logic [1:0]        error;
    } res_t;

    // corner of face f at ring position e
    function automatic logic [2:0] face_corner(input logic [2:0] f, input logic [1:0] e);
        logic [11:0] row;
        unique case (f)
            3'd0:    row = {3'd2, 3'd3, 3'd1, 3'd0};
            3'd1:    row = {3'd6, 3'd7, 3'd5, 3'd4};
            3'd2:    row = {3'd4, 3'd5, 3'd1, 3'd0};
            3'd3:    row = {3'd6, 3'd7, 3'd3, 3'd2};
            3'd4:    row = {3'd4, 3'd6, 3'd2, 3'd0};
            3'd5:    row = {3'd5, 3'd7, 3'd3, 3'd1};
            default: row = '0;
        endcase
        return row[e*3 +: 3];
    endfunction

    // three smallest of four indices, ascending
    function automatic logic [KEY_W-1:0] face_key(input logic [VIDX_W-1:0] a,
                                                  input logic [VIDX_W-1:0] b,
                                                  input logic [VIDX_W-1:0] c,
                                                  input logic [VIDX_W-1:0] d);
        logic [VIDX_W-1:0] lo0, hi0, lo1, hi1, s0, m0, m1;
        lo0 = (a < b) ? a : b;
        hi0 = (a < b) ? b : a;
        lo1 = (c < d) ? c : d;
        hi1 = (c < d) ? d : c;
        s0  = (lo0 < lo1) ? lo0 : lo1;
        m0  = (lo0 < lo1) ? lo1 : lo0;
        m1  = (hi0 < hi1) ? hi0 : hi1;
        return {s0, ((m0 < m1) ? m0 : m1), ((m0 < m1) ? m1 : m0)};
    endfunction

endpackage

FILE: rtl/core/htt_in_if.sv
interface htt_in_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   cmd;
    logic [htt_pkg::VIDX_W-1:0]   corner_0;
    logic [htt_pkg::VIDX_W-1:0]   corner_1;
    logic [htt_pkg::VIDX_W-1:0]   corner_2;
    logic [htt_pkg::VIDX_W-1:0]   corner_3;
    logic [htt_pkg::VIDX_W-1:0]   corner_4;
    logic [htt_pkg::VIDX_W-1:0]   corner_5;
    logic [htt_pkg::VIDX_W-1:0]   corner_6;
    logic [htt_pkg::VIDX_W-1:0]   corner_7;
    logic signed [31:0]           load_x;
    logic signed [31:0]           load_y;
    logic signed [31:0]           load_z;

    modport source (
        output valid, cmd, corner_0, corner_1, corner_2, corner_3,
               corner_4, corner_5, corner_6, corner_7, load_x, load_y, load_z,
        input  ready
    );
    modport sink (
        input  valid, cmd, corner_0, corner_1, corner_2, corner_3,
               corner_4, corner_5, corner_6, corner_7, load_x, load_y, load_z,
        output ready
    );
endinterface

FILE: rtl/core/htt_out_if.sv
interface htt_out_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   kind;
    logic [htt_pkg::VIDX_W-1:0]   node_a;
    logic [htt_pkg::VIDX_W-1:0]   node_b;
    logic [htt_pkg::VIDX_W-1:0]   node_c;
    logic [htt_pkg::VIDX_W-1:0]   node_d;
    logic signed [31:0]           coord_x;
    logic signed [31:0]           coord_y;
    logic signed [31:0]           coord_z;
    logic                         last;
    logic [1:0]                   error;

    modport source (
        output valid, kind, node_a, node_b, node_c, node_d,
               coord_x, coord_y, coord_z, last, error,
        input  ready
    );
    modport sink (
        input  valid, kind, node_a, node_b, node_c, node_d,
               coord_x, coord_y, coord_z, last, error,
        output ready
    );
endinterface

FILE: rtl/core/htt_ram.sv
module htt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/core/htt_acc.sv
module htt_acc (
    input  logic                        clk,
    input  logic                        clr,
    input  logic                        add,
    input  logic                        quarter,
    input  logic [htt_pkg::XYZ_W-1:0]   din,
    output logic [htt_pkg::XYZ_W-1:0]   avg
);
    import htt_pkg::*;

    logic signed [ACC_W-1:0] acc_reg [3];
    logic signed [ACC_W-1:0] acc_next [3];
    logic signed [ACC_W-1:0] shifted [3];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            acc_next[a] = acc_reg[a];
            if (clr)
            begin
                acc_next[a] = '0;
            end
            else if (add)
            begin
                acc_next[a] = acc_reg[a]
                    + ACC_W'($signed(din[(2-a)*COORD_BITS +: COORD_BITS]));
            end
            // floor division by 4 or 8
            shifted[a] = quarter ? (acc_reg[a] >>> 2) : (acc_reg[a] >>> 3);
            avg[(2-a)*COORD_BITS +: COORD_BITS] = shifted[a][COORD_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 3; a++)
        begin
            acc_reg[a] <= acc_next[a];
        end
    end
endmodule

FILE: rtl/core/hex_to_tet_splitter.sv
// Hexahedron to 24-tetrahedra splitter.
// items (sink): one transaction per command. A load writes the Q16.16
//   coordinates of vertex corner_0. A hexahedron split fetches the 8 corner
//   coordinates through one accumulator, then for each of its 6 faces searches
//   the face table linearly (one entry per cycle, up to face-table fill) and,
//   on a miss, fetches 4 corners for the face centre. It then emits up to 7
//   new vertices followed by 24 tetrahedra, one per cycle while the receiver
//   takes them, or one error result if the face table is full at the start.
//   A face split searches the table and emits 4 triangles, or one error result
//   when the face centre is unknown.
// items.ready is high only while idle, so one transaction is handled at a time;
//   the search loop over the face table and the single coordinate memory read
//   port set the per-transaction time.
// results (source): registered output; a stalled receiver holds the result and
//   the sequencer waits; last marks the final result of a transaction.
// cfg_wr_en/cfg_wr_data: writes base_reg, the base of the new vertex indices.
// Reset clears the sequencer, face count, new vertex count and base register;
//   the coordinate store and the face table start undefined and need no sweep.
module hex_to_tet_splitter (
    input  logic                        clk,
    input  logic                        rst_n,
    htt_in_if.sink                      items,
    htt_out_if.source                   results,
    input  logic                        cfg_wr_en,
    input  logic [htt_pkg::VIDX_W-1:0]  cfg_wr_data
);
    import htt_pkg::*;

    state_t state_reg, state_next;

    logic [VIDX_W-1:0]  corner_reg [HEX_CORNERS];
    logic [VIDX_W-1:0]  centre_reg [6];
    logic [VIDX_W-1:0]  vbuf_idx   [MAX_NEW_VTX];
    logic [XYZ_W-1:0]   vbuf_xyz   [MAX_NEW_VTX];

    logic [4:0]         cnt_reg, cnt_next;
    logic [2:0]         face_reg, face_next;
    logic [2:0]         nv_reg, nv_next;
    logic [FCNT_W-1:0]  srch_reg, srch_next;
    logic               pend_reg, pend_next;
    logic               qmode_reg, qmode_next;
    logic               err_reg, err_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [VIDX_W-1:0]  cell_reg, cell_next;
    logic [FCNT_W-1:0]  fc_reg, fc_next;
    logic [VIDX_W-1:0]  nvc_reg, nvc_next;
    logic [VIDX_W-1:0]  base_reg;
    logic               rv_reg, rv_next;
    res_t               res_reg, res_next;

    logic               in_fire, out_ok, full, issue_acc, acc_done, issue_srch, hit, miss;
    logic               corner_we, centre_we, vbuf_we;
    logic [2:0]         centre_sel, vbuf_sel;
    logic [VIDX_W-1:0]  centre_val;
    logic [VIDX_W-1:0]  new_idx;
    logic [2:0]         csel;
    logic [VIDX_W-1:0]  sel_corner;
    logic [XYZ_W-1:0]   coord_rdata, avg;
    logic               acc_clr, acc_add;
    logic               tbl_we;
    logic [KEY_W+VIDX_W-1:0] tbl_rdata;
    logic [2:0]         emit_f;
    logic [1:0]         emit_e;

    assign in_fire    = items.valid & items.ready;
    assign items.ready = (state_reg == S_IDLE);
    assign out_ok     = !rv_reg || results.ready;
    assign full       = (fc_reg >= FCNT_W'(FACE_SLOTS));
    assign new_idx    = base_reg + nvc_reg;
    assign issue_acc  = (state_reg == S_CELL_ACC) ? (cnt_reg < 5'(HEX_CORNERS))
                                                  : (cnt_reg < 5'(QUAD_CORNERS));
    assign acc_done   = !issue_acc && !pend_reg;
    assign issue_srch = (srch_reg < fc_reg);
    assign hit        = pend_reg && (tbl_rdata[KEY_W+VIDX_W-1:VIDX_W] == key_reg);
    assign miss       = !issue_srch && !pend_reg;
    assign emit_f     = cnt_reg[4:2];
    assign emit_e     = cnt_reg[1:0];

    // corner feeding the coordinate read port
    assign csel       = (state_reg == S_CELL_ACC) ? cnt_reg[2:0]
                                                  : face_corner(face_reg, cnt_reg[1:0]);
    assign sel_corner = corner_reg[csel];
    assign acc_add    = pend_reg && ((state_reg == S_CELL_ACC) || (state_reg == S_FACE_ACC));

    htt_ram #(.WIDTH(XYZ_W), .DEPTH(MAX_VERTICES)) u_coord (
        .clk   (clk),
        .we    (in_fire && (items.cmd == CMD_LOAD)),
        .waddr (items.corner_0[VADDR_W-1:0]),
        .wdata ({items.load_x, items.load_y, items.load_z}),
        .raddr (sel_corner[VADDR_W-1:0]),
        .rdata (coord_rdata)
    );

    htt_ram #(.WIDTH(KEY_W + VIDX_W), .DEPTH(FACE_SLOTS)) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (fc_reg[FADDR_W-1:0]),
        .wdata ({key_reg, new_idx}),
        .raddr (srch_reg[FADDR_W-1:0]),
        .rdata (tbl_rdata)
    );

    htt_acc u_acc (
        .clk     (clk),
        .clr     (acc_clr),
        .add     (acc_add),
        .quarter (state_reg == S_FACE_ACC),
        .din     (coord_rdata),
        .avg     (avg)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (items.cmd)
                        CMD_HEX:  state_next = full ? S_FULL : S_CELL_ACC;
                        CMD_FACE: state_next = S_KEY;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_FULL:     if (out_ok) state_next = S_IDLE;
            S_CELL_ACC: if (acc_done) state_next = S_KEY;
            S_KEY:      state_next = S_SEARCH;
            S_SEARCH:
            begin
                if (hit)
                begin
                    state_next = qmode_reg ? S_Q_EMIT
                               : ((face_reg == 3'd5) ? S_EMIT_V : S_KEY);
                end
                else if (miss)
                begin
                    state_next = qmode_reg ? S_Q_ERR : S_FACE_ACC;
                end
            end
            S_FACE_ACC:
            begin
                if (acc_done)
                begin
                    state_next = (face_reg == 3'd5) ? S_EMIT_V : S_KEY;
                end
            end
            S_EMIT_V:   if (out_ok && (cnt_reg[2:0] == nv_reg - 3'd1)) state_next = S_EMIT_T;
            S_EMIT_T:   if (out_ok && (cnt_reg == 5'(HEX_TETS - 1))) state_next = S_IDLE;
            S_Q_EMIT:   if (out_ok && (cnt_reg == 5'(QUAD_CORNERS - 1))) state_next = S_IDLE;
            S_Q_ERR:    if (out_ok) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cnt_next   = cnt_reg;
        face_next  = face_reg;
        nv_next    = nv_reg;
        srch_next  = srch_reg;
        pend_next  = 1'b0;
        qmode_next = qmode_reg;
        err_next   = err_reg;
        key_next   = key_reg;
        cell_next  = cell_reg;
        fc_next    = fc_reg;
        nvc_next   = nvc_reg;
        rv_next    = rv_reg && !results.ready;
        res_next   = res_reg;
        corner_we  = 1'b0;
        centre_we  = 1'b0;
        centre_sel = face_reg;
        centre_val = new_idx;
        vbuf_we    = 1'b0;
        vbuf_sel   = nv_reg;
        acc_clr    = 1'b0;
        tbl_we     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    corner_we  = 1'b1;
                    qmode_next = (items.cmd == CMD_FACE);
                    face_next  = '0;
                    cnt_next   = '0;
                    nv_next    = '0;
                    err_next   = 1'b0;
                    acc_clr    = 1'b1;
                end
            end
            S_FULL:
            begin
                if (out_ok)
                begin
                    rv_next  = 1'b1;
                    res_next = '{kind: KIND_VERTEX, last: 1'b1, error: ERR_FULL, default: '0};
                end
            end
            S_CELL_ACC, S_FACE_ACC:
            begin
                if (issue_acc)
                begin
                    cnt_next  = cnt_reg + 5'd1;
                    pend_next = 1'b1;
                end
                if (acc_done)
                begin
                    vbuf_we  = 1'b1;
                    nv_next  = nv_reg + 3'd1;
                    nvc_next = nvc_reg + VIDX_W'(1);
                    cnt_next = '0;
                    if (state_reg == S_CELL_ACC)
                    begin
                        cell_next = new_idx;
                    end
                    else
                    begin
                        centre_we = 1'b1;
                        face_next = face_reg + 3'd1;
                        if (!full)
                        begin
                            tbl_we  = 1'b1;
                            fc_next = fc_reg + FCNT_W'(1);
                        end
                        else
                        begin
                            err_next = 1'b1;
                        end
                    end
                end
            end
            S_KEY:
            begin
                key_next  = face_key(corner_reg[face_corner(face_reg, 2'd0)],
                                     corner_reg[face_corner(face_reg, 2'd1)],
                                     corner_reg[face_corner(face_reg, 2'd2)],
                                     corner_reg[face_corner(face_reg, 2'd3)]);
                srch_next = '0;
            end
            S_SEARCH:
            begin
                if (issue_srch)
                begin
                    srch_next = srch_reg + FCNT_W'(1);
                end
                pend_next = issue_srch && !hit;
                if (hit)
                begin
                    centre_we  = 1'b1;
                    centre_val = tbl_rdata[VIDX_W-1:0];
                    face_next  = face_reg + 3'd1;
                    cnt_next   = '0;
                end
                else if (miss)
                begin
                    cnt_next = '0;
                    acc_clr  = 1'b1;
                end
            end
            S_EMIT_V:
            begin
                if (out_ok)
                begin
                    rv_next  = 1'b1;
                    res_next = '{kind: KIND_VERTEX, node_a: vbuf_idx[cnt_reg[2:0]],
                                 coord_x: vbuf_xyz[cnt_reg[2:0]][2*COORD_BITS +: OUT_C_W],
                                 coord_y: vbuf_xyz[cnt_reg[2:0]][COORD_BITS +: OUT_C_W],
                                 coord_z: vbuf_xyz[cnt_reg[2:0]][0 +: OUT_C_W],
                                 error: err_reg ? ERR_FULL : ERR_NONE, default: '0};
                    cnt_next = (cnt_reg[2:0] == nv_reg - 3'd1) ? 5'd0 : cnt_reg + 5'd1;
                end
            end
            S_EMIT_T:
            begin
                if (out_ok)
                begin
                    rv_next  = 1'b1;
                    res_next = '{kind: KIND_TET,
                                 node_a: corner_reg[face_corner(emit_f, emit_e)],
                                 node_b: corner_reg[face_corner(emit_f, emit_e + 2'd1)],
                                 node_c: centre_reg[emit_f],
                                 node_d: cell_reg,
                                 last: (cnt_reg == 5'(HEX_TETS - 1)),
                                 error: err_reg ? ERR_FULL : ERR_NONE, default: '0};
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            S_Q_EMIT:
            begin
                if (out_ok)
                begin
                    rv_next  = 1'b1;
                    res_next = '{kind: KIND_TRI,
                                 node_a: corner_reg[face_corner(3'd0, emit_e)],
                                 node_b: corner_reg[face_corner(3'd0, emit_e + 2'd1)],
                                 node_c: centre_reg[0],
                                 last: (cnt_reg == 5'(QUAD_CORNERS - 1)),
                                 error: ERR_NONE, default: '0};
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            S_Q_ERR:
            begin
                if (out_ok)
                begin
                    rv_next  = 1'b1;
                    res_next = '{kind: KIND_TRI, last: 1'b1, error: ERR_NO_FACE, default: '0};
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fc_reg    <= '0;
            nvc_reg   <= '0;
            base_reg  <= '0;
            rv_reg    <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fc_reg    <= fc_next;
            nvc_reg   <= nvc_next;
            rv_reg    <= rv_next;
            pend_reg  <= pend_next;
            if (cfg_wr_en)
            begin
                base_reg <= cfg_wr_data;
            end
        end
    end

    // payload: hold unless advanced
    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        face_reg  <= face_next;
        nv_reg    <= nv_next;
        srch_reg  <= srch_next;
        qmode_reg <= qmode_next;
        err_reg   <= err_next;
        key_reg   <= key_next;
        cell_reg  <= cell_next;
        res_reg   <= res_next;
        if (corner_we)
        begin
            corner_reg[0] <= items.corner_0;
            corner_reg[1] <= items.corner_1;
            corner_reg[2] <= items.corner_2;
            corner_reg[3] <= items.corner_3;
            corner_reg[4] <= items.corner_4;
            corner_reg[5] <= items.corner_5;
            corner_reg[6] <= items.corner_6;
            corner_reg[7] <= items.corner_7;
        end
        if (centre_we)
        begin
            centre_reg[centre_sel] <= centre_val;
        end
        if (vbuf_we)
        begin
            vbuf_idx[vbuf_sel] <= new_idx;
            vbuf_xyz[vbuf_sel] <= avg;
        end
    end

    assign results.valid   = rv_reg;
    assign results.kind    = res_reg.kind;
    assign results.node_a  = res_reg.node_a;
    assign results.node_b  = res_reg.node_b;
    assign results.node_c  = res_reg.node_c;
    assign results.node_d  = res_reg.node_d;
    assign results.coord_x = res_reg.coord_x;
    assign results.coord_y = res_reg.coord_y;
    assign results.coord_z = res_reg.coord_z;
    assign results.last    = res_reg.last;
    assign results.error   = res_reg.error;
endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import htt_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 64;
    localparam int LONG_HOLD      = 400;

    // one input transaction as the block sees it
    typedef struct {
        logic [1:0]         cmd;
        logic [15:0]        corner [8];
        logic signed [31:0] lx;
        logic signed [31:0] ly;
        logic signed [31:0] lz;
    } job_t;

    // ring order of the four corners of each hexahedron face
    localparam int HEX_RING [6][4] = '{
        '{0, 1, 3, 2}, '{4, 5, 7, 6}, '{0, 1, 5, 4},
        '{2, 3, 7, 6}, '{0, 2, 6, 4}, '{1, 3, 7, 5}
    };

    class split_scoreboard;
        logic signed [31:0] pos_x [int];
        logic signed [31:0] pos_y [int];
        logic signed [31:0] pos_z [int];
        logic [47:0]        known_keys [$];
        logic [15:0]        known_centres [$];
        logic [15:0]        base_index;
        logic [15:0]        made_count;
        res_t               due [$];
        int                 fails;

        function new();
            base_index = '0;
            made_count = '0;
            fails = 0;
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            fails++;
            $display("mismatch @%0t %s: got %h want %h", $realtime, what, got, want);
        endtask

        function void set_base(logic [15:0] v);
            base_index = v;
        endfunction

        function logic [15:0] next_index();
            logic [15:0] idx;
            idx = base_index + made_count;
            made_count = made_count + 16'd1;
            return idx;
        endfunction

        // floor of the mean over n corners on one axis
        function logic [31:0] mean_axis(logic [15:0] v [8], int n, int sh, int axis);
            longint s;
            s = 0;
            for (int i = 0; i < n; i++)
            begin
                case (axis)
                    0: s += pos_x[v[i]];
                    1: s += pos_y[v[i]];
                    default: s += pos_z[v[i]];
                endcase
            end
            return 32'(s >>> sh);
        endfunction

        function logic [47:0] key_of(logic [15:0] a, logic [15:0] b,
                                     logic [15:0] c, logic [15:0] d);
            logic [15:0] s [4];
            logic [15:0] t;
            s = '{a, b, c, d};
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3 - i; j++)
                begin
                    if (s[j + 1] < s[j])
                    begin
                        t = s[j];
                        s[j] = s[j + 1];
                        s[j + 1] = t;
                    end
                end
            end
            return {s[0], s[1], s[2]};
        endfunction

        function int find_face(logic [47:0] k);
            for (int i = 0; i < known_keys.size(); i++)
            begin
                if (known_keys[i] == k)
                begin
                    return i;
                end
            end
            return -1;
        endfunction

        function void split_hex(job_t j);
            logic [15:0] vidx [7];
            logic [31:0] vx [7];
            logic [31:0] vy [7];
            logic [31:0] vz [7];
            logic [15:0] centre [6];
            logic [15:0] fc [8];
            logic [47:0] k;
            logic [1:0]  err;
            logic [15:0] cell_idx;
            int          nv;
            int          hit;
            res_t        r;
            err = ERR_NONE;
            if (known_keys.size() >= FACE_SLOTS)
            begin
                r = '0;
                r.kind = KIND_VERTEX;
                r.error = ERR_FULL;
                r.last = 1'b1;
                due.push_back(r);
                return;
            end
            vx[0] = mean_axis(j.corner, 8, 3, 0);
            vy[0] = mean_axis(j.corner, 8, 3, 1);
            vz[0] = mean_axis(j.corner, 8, 3, 2);
            cell_idx = next_index();
            vidx[0] = cell_idx;
            nv = 1;
            for (int f = 0; f < 6; f++)
            begin
                fc = '{default: '0};
                for (int i = 0; i < 4; i++)
                begin
                    fc[i] = j.corner[HEX_RING[f][i]];
                end
                k = key_of(fc[0], fc[1], fc[2], fc[3]);
                hit = find_face(k);
                if (hit >= 0)
                begin
                    centre[f] = known_centres[hit];
                    continue;
                end
                vx[nv] = mean_axis(fc, 4, 2, 0);
                vy[nv] = mean_axis(fc, 4, 2, 1);
                vz[nv] = mean_axis(fc, 4, 2, 2);
                centre[f] = next_index();
                vidx[nv] = centre[f];
                nv++;
                if (known_keys.size() < FACE_SLOTS)
                begin
                    known_keys.push_back(k);
                    known_centres.push_back(centre[f]);
                end
                else
                begin
                    err = ERR_FULL;
                end
            end
            for (int i = 0; i < nv; i++)
            begin
                r = '0;
                r.kind = KIND_VERTEX;
                r.node_a = vidx[i];
                r.coord_x = vx[i];
                r.coord_y = vy[i];
                r.coord_z = vz[i];
                r.error = err;
                due.push_back(r);
            end
            for (int f = 0; f < 6; f++)
            begin
                for (int e = 0; e < 4; e++)
                begin
                    r = '0;
                    r.kind = KIND_TET;
                    r.node_a = j.corner[HEX_RING[f][e]];
                    r.node_b = j.corner[HEX_RING[f][(e + 1) % 4]];
                    r.node_c = centre[f];
                    r.node_d = cell_idx;
                    r.error = err;
                    r.last = (f == 5 && e == 3);
                    due.push_back(r);
                end
            end
        endfunction

        function void split_face(job_t j);
            int   hit;
            res_t r;
            hit = find_face(key_of(j.corner[0], j.corner[1], j.corner[2], j.corner[3]));
            if (hit < 0)
            begin
                r = '0;
                r.kind = KIND_TRI;
                r.error = ERR_NO_FACE;
                r.last = 1'b1;
                due.push_back(r);
                return;
            end
            for (int e = 0; e < 4; e++)
            begin
                r = '0;
                r.kind = KIND_TRI;
                r.node_a = j.corner[HEX_RING[0][e]];
                r.node_b = j.corner[HEX_RING[0][(e + 1) % 4]];
                r.node_c = known_centres[hit];
                r.last = (e == 3);
                due.push_back(r);
            end
        endfunction

        // note an accepted transaction and queue what it should produce
        function void note(job_t j);
            case (j.cmd)
                CMD_LOAD:
                begin
                    pos_x[j.corner[0]] = j.lx;
                    pos_y[j.corner[0]] = j.ly;
                    pos_z[j.corner[0]] = j.lz;
                end
                CMD_HEX:  split_hex(j);
                CMD_FACE: split_face(j);
                default: ;
            endcase
        endfunction

        task check(res_t got);
            res_t want;
            if (due.size() == 0)
            begin
                report("unexpected result", got.kind, '0);
                return;
            end
            want = due.pop_front();
            if (got.kind !== want.kind)       report("kind", got.kind, want.kind);
            if (got.node_a !== want.node_a)   report("node_a", got.node_a, want.node_a);
            if (got.node_b !== want.node_b)   report("node_b", got.node_b, want.node_b);
            if (got.node_c !== want.node_c)   report("node_c", got.node_c, want.node_c);
            if (got.node_d !== want.node_d)   report("node_d", got.node_d, want.node_d);
            if (got.coord_x !== want.coord_x) report("coord_x", got.coord_x, want.coord_x);
            if (got.coord_y !== want.coord_y) report("coord_y", got.coord_y, want.coord_y);
            if (got.coord_z !== want.coord_z) report("coord_z", got.coord_z, want.coord_z);
            if (got.last !== want.last)       report("last", got.last, want.last);
            if (got.error !== want.error)     report("error", got.error, want.error);
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        take = 1'b0;

    htt_in_if  items_if ();
    htt_out_if results_if ();

    assign results_if.ready = take;

    hex_to_tet_splitter u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .items       (items_if),
        .results     (results_if),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    split_scoreboard sb = new();

    int          send_idle_pct = 0;
    int          stall_pct = 0;
    bit          long_hold_req = 1'b0;
    bit          long_hold_done = 1'b0;
    int          hold_left = 0;
    int          quiet_cycles = 0;

    logic [15:0] pool [16];
    logic [15:0] hex_log [$][8];
    logic [15:0] face_log [$][4];

    // receiver: random stalls, plus one long hold-off while the sender keeps pushing
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            take <= 1'b0;
        end
        else if (long_hold_req && !long_hold_done)
        begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD;
            take <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            take <= 1'b0;
        end
        else
        begin
            take <= ($urandom_range(99) >= stall_pct);
        end
    end

    // check every result transaction against the oldest prediction
    always @(posedge clk)
    begin
        res_t got;
        if (rst_n && results_if.valid && results_if.ready)
        begin
            got.kind = results_if.kind;
            got.node_a = results_if.node_a;
            got.node_b = results_if.node_b;
            got.node_c = results_if.node_c;
            got.node_d = results_if.node_d;
            got.coord_x = results_if.coord_x;
            got.coord_y = results_if.coord_y;
            got.coord_z = results_if.coord_z;
            got.last = results_if.last;
            got.error = results_if.error;
            sb.check(got);
        end
    end

    // watchdog: end the run when neither side moves for too long
    always @(posedge clk)
    begin
        if ((items_if.valid && items_if.ready) || (results_if.valid && results_if.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // offer one transaction, hold it until the block takes it, then record it
    task automatic push_item(job_t j);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            items_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        items_if.cmd <= j.cmd;
        items_if.corner_0 <= j.corner[0];
        items_if.corner_1 <= j.corner[1];
        items_if.corner_2 <= j.corner[2];
        items_if.corner_3 <= j.corner[3];
        items_if.corner_4 <= j.corner[4];
        items_if.corner_5 <= j.corner[5];
        items_if.corner_6 <= j.corner[6];
        items_if.corner_7 <= j.corner[7];
        items_if.load_x <= j.lx;
        items_if.load_y <= j.ly;
        items_if.load_z <= j.lz;
        items_if.valid <= 1'b1;
        do
            @(posedge clk);
        while (!items_if.ready);
        sb.note(j);
        if (j.cmd == CMD_HEX)
        begin
            hex_log.push_back(j.corner);
            for (int f = 0; f < 6; f++)
            begin
                face_log.push_back('{j.corner[HEX_RING[f][0]], j.corner[HEX_RING[f][1]],
                                     j.corner[HEX_RING[f][3]], j.corner[HEX_RING[f][2]]});
            end
        end
    endtask

    // drop valid, wait for every predicted result, then let loads settle
    task automatic drain();
        items_if.valid <= 1'b0;
        while (sb.due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_base(logic [15:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_base(v);
    endtask

    function automatic job_t blank_job(logic [1:0] cmd);
        job_t j;
        j.cmd = cmd;
        for (int i = 0; i < 8; i++)
        begin
            j.corner[i] = 16'($urandom);
        end
        j.lx = $urandom;
        j.ly = $urandom;
        j.lz = $urandom;
        return j;
    endfunction

    function automatic job_t load_job(logic [15:0] v);
        job_t j;
        j = blank_job(CMD_LOAD);
        j.corner[0] = v;
        return j;
    endfunction

    // hex from loaded vertices; half the time glued onto an earlier hex
    function automatic job_t hex_job();
        job_t j;
        j = blank_job(CMD_HEX);
        for (int i = 0; i < 8; i++)
        begin
            j.corner[i] = pool[$urandom_range(15)];
        end
        if (hex_log.size() > 0 && $urandom_range(1))
        begin
            logic [15:0] prev [8];
            prev = hex_log[$urandom_range(hex_log.size() - 1)];
            for (int i = 0; i < 4; i++)
            begin
                j.corner[i] = prev[i + 4];
            end
        end
        return j;
    endfunction

    // face split: mostly a known face in rotated order, else random corners
    function automatic job_t face_job();
        job_t        j;
        logic [15:0] q [4];
        int          rot;
        j = blank_job(CMD_FACE);
        if (face_log.size() > 0 && $urandom_range(99) < 70)
        begin
            q = face_log[$urandom_range(face_log.size() - 1)];
            rot = $urandom_range(3);
            for (int i = 0; i < 4; i++)
            begin
                j.corner[i] = q[(i + rot) % 4];
            end
        end
        return j;
    endfunction

    function automatic job_t random_job();
        int pick;
        pick = $urandom_range(99);
        if (pick < 15)
            return load_job(pool[$urandom_range(15)]);
        else if (pick < 60)
            return hex_job();
        else if (pick < 95)
            return face_job();
        else
            return blank_job(2'd3);
    endfunction

    initial
    begin
        job_t        j;
        logic [15:0] bases [4];

        items_if.valid = 1'b0;
        items_if.cmd = CMD_LOAD;
        items_if.corner_0 = '0;
        items_if.corner_1 = '0;
        items_if.corner_2 = '0;
        items_if.corner_3 = '0;
        items_if.corner_4 = '0;
        items_if.corner_5 = '0;
        items_if.corner_6 = '0;
        items_if.corner_7 = '0;
        items_if.load_x = '0;
        items_if.load_y = '0;
        items_if.load_z = '0;

        pool[0] = 16'h0000;
        pool[1] = 16'hFFFF;
        pool[2] = 16'h5555;
        pool[3] = 16'hAAAA;
        for (int i = 4; i < 16; i++)
        begin
            pool[i] = 16'($urandom);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_base(16'h0000);

        // directed: load every vertex used later, coordinates at the extremes first
        for (int i = 0; i < 16; i++)
        begin
            j = load_job(pool[i]);
            case (i)
                0: begin j.lx = 32'sh80000000; j.ly = 32'sh80000000; j.lz = 32'sh80000000; end
                1: begin j.lx = 32'sh7FFFFFFF; j.ly = 32'sh7FFFFFFF; j.lz = 32'sh7FFFFFFF; end
                2: begin j.lx = 0; j.ly = -1; j.lz = 1; end
                default: ;
            endcase
            push_item(j);
        end
        // unused command, all bits set
        j = blank_job(2'd3);
        j.corner = '{default: 16'hFFFF};
        j.lx = -1;
        j.ly = -1;
        j.lz = -1;
        push_item(j);
        // plain hex over distinct corners, then one that half the time is glued to it
        j = blank_job(CMD_HEX);
        for (int i = 0; i < 8; i++)
        begin
            j.corner[i] = pool[i];
        end
        push_item(j);
        push_item(hex_job());
        // all corners the same vertex: every face shares one key
        j = blank_job(CMD_HEX);
        j.corner = '{default: pool[1]};
        push_item(j);
        // a face that is known most of the time, then a face the table has never seen
        push_item(face_job());
        j = blank_job(CMD_FACE);
        j.corner[0] = 16'h1234;
        j.corner[1] = 16'h1234;
        j.corner[2] = 16'h4321;
        j.corner[3] = 16'h0F0F;
        push_item(j);
        // pause until the block has delivered everything
        drain();

        bases[0] = 16'hFFFF;
        bases[1] = 16'($urandom);
        bases[2] = 16'h0001;
        bases[3] = 16'h0000;
        for (int phase = 0; phase < 4; phase++)
        begin
            write_base(bases[phase]);
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 85; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 85; end
                default: begin send_idle_pct = 21; stall_pct = 21; end
            endcase
            // fill the block against a receiver that holds off for a long stretch
            if (phase == 0)
            begin
                long_hold_req = 1'b1;
            end
            for (int n = 0; n < 32; n++)
            begin
                push_item(random_job());
            end
            drain();
        end

        if (sb.fails == 0)
        begin
            $display("tb passed");
        end
        else
        begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
